// File: sv/timed_slot_table_oldest_evict_assert.svh
// Assertion macros shared by the timed slot table RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef TIMED_SLOT_TABLE_OLDEST_EVICT_ASSERT_SVH
`define TIMED_SLOT_TABLE_OLDEST_EVICT_ASSERT_SVH

// Checked property, switched off while reset is asserted.
`define TSOE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked property that must also hold while reset is asserted.
`define TSOE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/tsoe_pkg.sv
// Package for the timed slot table: command codes and field widths.
// No dependencies; imported by timed_slot_table_oldest_evict and its testbench.
`timescale 1ns / 1ps
`default_nettype none

package tsoe_pkg;

    // Command codes of an input transaction.
    typedef enum logic [1:0] {
        CMD_POST    = 2'd0,
        CMD_TICK    = 2'd1,
        CMD_DISMISS = 2'd2,
        CMD_NOP     = 2'd3
    } cmd_t;

    // Fixed field widths of the ports.
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned TIMEOUT_W = 22;
    localparam int unsigned KIND_W    = 2;
    localparam int unsigned SLOT_W    = 2;
    localparam int unsigned MASK_W    = 4;
    localparam int unsigned COUNT_W   = 3;

    // Reset value of the timeout register, in milliseconds.
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(5000);

endpackage

`default_nettype wire

// File: sv/timed_slot_table_oldest_evict.sv
// Timed slot table with oldest-first eviction, top level.
// Depends on tsoe_pkg and on timed_slot_table_oldest_evict_assert.svh.
//
//  Channel    Handshake            Payload
//  ---------  -------------------  ---------------------------------------------
//  command    start / busy         cmd, now_ms, kind, slot_index
//  result     done (one cycle)     slot_used, evicted, expired_mask, active_count
//  config     timeout_we           timeout_ms
//
// One transaction is accepted per cycle; busy never rises.
// done is high in the cycle after the command register loads. The slot search
// (free slot priority, oldest stamp tree) sits between the command register
// and the result register.
// rst_n clears slot busy bits and all strobes, and sets timeout to TIMEOUT_RESET.
// The receiver cannot stall, so results are never held back.
`timescale 1ns / 1ps
`default_nettype none

module timed_slot_table_oldest_evict #(
    parameter int unsigned SLOTS = 4
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    // Command channel
    input  wire                                  start,
    output logic                                 busy,
    input  tsoe_pkg::cmd_t                       cmd,
    input  wire  [tsoe_pkg::TIME_W-1:0]          now_ms,
    input  wire  [tsoe_pkg::KIND_W-1:0]          kind,
    input  wire  [tsoe_pkg::SLOT_W-1:0]          slot_index,
    // Configuration
    input  wire                                  timeout_we,
    input  wire  [tsoe_pkg::TIMEOUT_W-1:0]       timeout_ms,
    // Result channel
    output logic                                 done,
    output logic [tsoe_pkg::SLOT_W-1:0]          slot_used,
    output logic                                 evicted,
    output logic [tsoe_pkg::MASK_W-1:0]          expired_mask,
    output logic [tsoe_pkg::COUNT_W-1:0]         active_count
);

    import tsoe_pkg::*;

    localparam int unsigned IDX_W  = $clog2(SLOTS);
    localparam int unsigned CNT_W  = $clog2(SLOTS + 1);
    localparam int unsigned LEAVES = 1 << IDX_W;

    // Command register.
    logic                  in_valid_reg;
    cmd_t                  cmd_reg;
    logic [TIME_W-1:0]     now_reg;
    logic [KIND_W-1:0]     kind_reg;
    logic [SLOT_W-1:0]     idx_reg;

    // Slot state and configuration.
    logic [SLOTS-1:0]      slot_busy_reg;
    logic [SLOTS-1:0]      slot_busy_next;
    logic [TIME_W-1:0]     slot_stamp_reg [SLOTS];
    logic [KIND_W-1:0]     slot_kind_reg  [SLOTS];
    logic [TIMEOUT_W-1:0]  timeout_reg;

    // Result register.
    logic                  done_reg;
    logic [SLOT_W-1:0]     slot_used_reg;
    logic [SLOT_W-1:0]     slot_used_next;
    logic                  evicted_reg;
    logic                  evicted_next;
    logic [MASK_W-1:0]     expired_reg;
    logic [MASK_W-1:0]     expired_next;
    logic [COUNT_W-1:0]    count_reg;
    logic [COUNT_W-1:0]    count_next;

    // Search results.
    logic                  free_found;
    logic [IDX_W-1:0]      free_idx;
    logic [IDX_W-1:0]      victim;
    logic [SLOTS-1:0]      expire_vec;
    logic [CNT_W-1:0]      busy_sum;

    // Min tree over stamps, heap ordered: node n combines 2n and 2n+1.
    logic [TIME_W-1:0]     tree_stamp [2*LEAVES];
    logic [IDX_W-1:0]      tree_idx   [2*LEAVES];
    logic                  tree_vld   [2*LEAVES];

    assign busy = 1'b0;

    // Command register captures every accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_reg  <= cmd;
            now_reg  <= now_ms;
            kind_reg <= kind;
            idx_reg  <= slot_index;
        end
    end

    // Lowest free slot, found by priority from the top down.
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!slot_busy_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // Oldest stamp; the right child wins only when strictly smaller, so ties
    // go to the lower index.
    always_comb
    begin
        for (int i = 0; i < LEAVES; i++)
        begin
            tree_idx[LEAVES + i] = IDX_W'(i);
            if (i < SLOTS)
            begin
                tree_stamp[LEAVES + i] = slot_stamp_reg[i];
                tree_vld[LEAVES + i]   = 1'b1;
            end
            else
            begin
                tree_stamp[LEAVES + i] = '1;
                tree_vld[LEAVES + i]   = 1'b0;
            end
        end
        tree_stamp[0] = '1;
        tree_idx[0]   = '0;
        tree_vld[0]   = 1'b0;
        for (int n = LEAVES - 1; n >= 1; n--)
        begin
            if (tree_vld[2*n+1] && (!tree_vld[2*n] || tree_stamp[2*n+1] < tree_stamp[2*n]))
            begin
                tree_stamp[n] = tree_stamp[2*n+1];
                tree_idx[n]   = tree_idx[2*n+1];
                tree_vld[n]   = 1'b1;
            end
            else
            begin
                tree_stamp[n] = tree_stamp[2*n];
                tree_idx[n]   = tree_idx[2*n];
                tree_vld[n]   = tree_vld[2*n];
            end
        end
    end

    assign victim = free_found ? free_idx : tree_idx[1];

    // Slots whose wrap-safe age has reached the timeout.
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            expire_vec[i] = slot_busy_reg[i]
                && ((now_reg - slot_stamp_reg[i]) >= {{(TIME_W-TIMEOUT_W){1'b0}}, timeout_reg});
        end
    end

    // Next slot state and result fields for the registered command.
    always_comb
    begin
        slot_busy_next = slot_busy_reg;
        slot_used_next = '0;
        evicted_next   = 1'b0;
        expired_next   = '0;
        if (in_valid_reg)
        begin
            unique case (cmd_reg)
                CMD_POST:
                begin
                    slot_busy_next[victim] = 1'b1;
                    slot_used_next         = SLOT_W'(victim);
                    evicted_next           = !free_found;
                end
                CMD_TICK:
                begin
                    slot_busy_next = slot_busy_reg & ~expire_vec;
                    expired_next   = MASK_W'(expire_vec);
                end
                CMD_DISMISS:
                begin
                    if (32'(idx_reg) < SLOTS)
                    begin
                        slot_busy_next[IDX_W'(idx_reg)] = 1'b0;
                    end
                end
                CMD_NOP:
                begin
                    slot_busy_next = slot_busy_reg;
                end
                default:
                begin
                    slot_busy_next = slot_busy_reg;
                end
            endcase
        end
    end

    // Population count of the busy bits after the step.
    always_comb
    begin
        busy_sum = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            busy_sum = busy_sum + CNT_W'(slot_busy_next[i]);
        end
    end

    assign count_next = COUNT_W'(busy_sum);

    // Control state: busy bits, timeout and result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_busy_reg <= '0;
            timeout_reg   <= TIMEOUT_RESET;
            done_reg      <= 1'b0;
        end
        else
        begin
            slot_busy_reg <= slot_busy_next;
            done_reg      <= in_valid_reg;
            if (timeout_we)
            begin
                timeout_reg <= timeout_ms;
            end
        end
    end

    // Stamp and kind of the slot claimed by a post.
    always_ff @(posedge clk)
    begin
        if (in_valid_reg && cmd_reg == CMD_POST)
        begin
            slot_stamp_reg[victim] <= now_reg;
            slot_kind_reg[victim]  <= kind_reg;
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            slot_used_reg <= slot_used_next;
            evicted_reg   <= evicted_next;
            expired_reg   <= expired_next;
            count_reg     <= count_next;
        end
    end

    assign done         = done_reg;
    assign slot_used    = slot_used_reg;
    assign evicted      = evicted_reg;
    assign expired_mask = expired_reg;
    assign active_count = count_reg;

    `include "timed_slot_table_oldest_evict_assert.svh"

    // Every accepted transaction yields its result via the command register and the done register.
    `TSOE_ASSERT(a_result_latency, (start && !busy) |-> ##2 done, "late or missing result")

    // An eviction only happens when the table is full, and it stays full.
    `TSOE_ASSERT(a_evict_full, (done && evicted) |-> (&slot_busy_reg), "eviction left a free slot")

    // An expiry sweep never reports a claimed slot or an eviction.
    `TSOE_ASSERT(a_tick_clean, (done && |expired_mask) |-> !(evicted || |slot_used), "tick with post data")

    // No result strobe while reset is asserted.
    `TSOE_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !done, "result strobe during reset")

endmodule

`default_nettype wire

// File: tb/timed_slot_table_oldest_evict_tb.sv
// Self-checking testbench for timed_slot_table_oldest_evict.
// Depends on tsoe_pkg and the RTL top level; it drives commands, takes each expected
// result from a directed row or its own copy of the slot table; it compares every field.
`timescale 1ns / 1ps

module timed_slot_table_oldest_evict_tb;

    import tsoe_pkg::*;

    localparam int unsigned SLOT_COUNT  = 4;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned PHASE_ITEMS = 160;

    // Expected content of one result transaction.
    typedef struct packed {
        logic [SLOT_W-1:0]  slot_used;
        logic               evicted;
        logic [MASK_W-1:0]  expired_mask;
        logic [COUNT_W-1:0] active_count;
    } outcome_t;

    // One row of the directed stimulus table.
    typedef struct {
        cmd_t              op;
        logic [TIME_W-1:0] stamp;
        logic [KIND_W-1:0] sort;
        logic [SLOT_W-1:0] target;
        bit                typed;
        outcome_t          want;
    } step_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    cmd_t                 cmd;
    logic [TIME_W-1:0]    now_ms;
    logic [KIND_W-1:0]    kind;
    logic [SLOT_W-1:0]    slot_index;
    logic                 timeout_we;
    logic [TIMEOUT_W-1:0] timeout_ms;
    logic                 done;
    logic [SLOT_W-1:0]    slot_used;
    logic                 evicted;
    logic [MASK_W-1:0]    expired_mask;
    logic [COUNT_W-1:0]   active_count;

    // Shadow copy of the slot table and the timeout register.
    bit                   slot_taken [SLOT_COUNT];
    logic [TIME_W-1:0]    slot_time  [SLOT_COUNT];
    logic [KIND_W-1:0]    slot_sort  [SLOT_COUNT];
    logic [TIMEOUT_W-1:0] timeout_setting;

    outcome_t    pending_outcomes[$];
    step_row_t   directed_rows[$];
    int unsigned fail_count;
    int unsigned cycle_count;
    int unsigned burst_left;
    int unsigned post_total;
    int unsigned evict_total;
    int unsigned expiry_total;
    int unsigned command_total;
    int unsigned setting_total;
    logic [TIME_W-1:0] wall_ms;

    timed_slot_table_oldest_evict #(
        .SLOTS(SLOT_COUNT)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .now_ms      (now_ms),
        .kind        (kind),
        .slot_index  (slot_index),
        .timeout_we  (timeout_we),
        .timeout_ms  (timeout_ms),
        .done        (done),
        .slot_used   (slot_used),
        .evicted     (evicted),
        .expired_mask(expired_mask),
        .active_count(active_count)
    );

    // Free-running clock, 20 ns period.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timed_slot_table_oldest_evict verification failed");
            $finish;
        end
    end

    // Apply one command to the shadow table and return the result it causes.
    function automatic outcome_t table_step(cmd_t op, logic [TIME_W-1:0] stamp,
                                            logic [KIND_W-1:0] sort,
                                            logic [SLOT_W-1:0] target);
        outcome_t          res;
        bit                found;
        logic [TIME_W-1:0] oldest;
        logic [TIME_W-1:0] age;
        int unsigned       pick;
        int unsigned       used_count;
        res = '0;
        found = 1'b0;
        pick = 0;
        if (op == CMD_POST)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                if (!found && !slot_taken[i])
                begin
                    pick = i;
                    found = 1'b1;
                end
            end
            // Table full: reuse the slot with the smallest raw stamp, lowest index on ties.
            if (!found)
            begin
                oldest = '1;
                pick = 0;
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    if (slot_time[i] < oldest)
                    begin
                        oldest = slot_time[i];
                        pick = i;
                    end
                end
                res.evicted = 1'b1;
            end
            slot_taken[pick] = 1'b1;
            slot_time[pick] = stamp;
            slot_sort[pick] = sort;
            res.slot_used = SLOT_W'(pick);
        end
        else if (op == CMD_TICK)
        begin
            // Age is taken modulo 2^32 so that the sweep survives a timer wrap.
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                age = stamp - slot_time[i];
                if (slot_taken[i] && age >= TIME_W'(timeout_setting))
                begin
                    slot_taken[i] = 1'b0;
                    res.expired_mask[i] = 1'b1;
                end
            end
        end
        else if (op == CMD_DISMISS)
        begin
            if (target < SLOT_COUNT)
                slot_taken[target] = 1'b0;
        end
        used_count = 0;
        for (int i = 0; i < SLOT_COUNT; i++)
            if (slot_taken[i])
                used_count++;
        res.active_count = COUNT_W'(used_count);
        return res;
    endfunction

    // Idle cycles before the next command: mostly none or short, a few long,
    // and occasional bursts with no idling at all.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (burst_left != 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            burst_left = $urandom_range(15, 40);
            return 0;
        end
        else if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic add_row(input cmd_t op, input logic [TIME_W-1:0] stamp,
                           input logic [KIND_W-1:0] sort, input logic [SLOT_W-1:0] target,
                           input bit typed, input int su, input int ev, input int em,
                           input int ac);
        step_row_t row;
        row.op = op;
        row.stamp = stamp;
        row.sort = sort;
        row.target = target;
        row.typed = typed;
        row.want.slot_used = SLOT_W'(su);
        row.want.evicted = ev[0];
        row.want.expired_mask = MASK_W'(em);
        row.want.active_count = COUNT_W'(ac);
        directed_rows.push_back(row);
    endtask

    // Drive one command transaction and record its expected result once accepted.
    task automatic issue_command(input cmd_t op, input logic [TIME_W-1:0] stamp,
                                 input logic [KIND_W-1:0] sort,
                                 input logic [SLOT_W-1:0] target,
                                 input bit typed, input outcome_t want);
        int unsigned gap;
        bit          taken;
        outcome_t    got;
        gap = pick_gap();
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd <= op;
        now_ms <= stamp;
        kind <= sort;
        slot_index <= target;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        got = table_step(op, stamp, sort, target);
        pending_outcomes.push_back(typed ? want : got);
        command_total++;
        if (op == CMD_POST)
            post_total++;
        if (got.evicted)
            evict_total++;
        if (got.expired_mask != '0)
            expiry_total++;
    endtask

    // Write the timeout register once all pending results have drained.
    task automatic load_timeout(input logic [TIMEOUT_W-1:0] value);
        start <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        timeout_we <= 1'b1;
        timeout_ms <= value;
        @(posedge clk);
        timeout_we <= 1'b0;
        timeout_setting = value;
        setting_total++;
    endtask

    // Random command with a time base that mostly moves forward and
    // sometimes lands right at a slot's expiry threshold.
    task automatic random_command();
        cmd_t        op;
        int unsigned r;
        int unsigned span;
        int unsigned j;
        logic [SLOT_W-1:0] target;
        span = int'(timeout_setting) + 1;
        r = $urandom_range(0, 99);
        if (r < 40)
            op = CMD_POST;
        else if (r < 70)
            op = CMD_TICK;
        else if (r < 90)
            op = CMD_DISMISS;
        else
            op = CMD_NOP;
        r = $urandom_range(0, 99);
        j = $urandom_range(0, SLOT_COUNT - 1);
        if (r < 10)
            wall_ms = wall_ms;
        else if (r < 55)
            wall_ms = wall_ms + TIME_W'($urandom_range(0, span / 4));
        else if (r < 75)
            wall_ms = wall_ms + TIME_W'($urandom_range(span / 2, span * 2));
        else if (r < 92 && slot_taken[j])
            wall_ms = slot_time[j] + TIME_W'(timeout_setting)
                      + TIME_W'($urandom_range(0, 2)) - 1;
        else
            wall_ms = $urandom();
        target = SLOT_W'($urandom_range(0, SLOT_COUNT - 1));
        if ($urandom_range(0, 9) < 7)
        begin
            // Prefer dismissing a slot that is actually in use.
            for (int i = 0; i < SLOT_COUNT; i++)
                if (slot_taken[(j + i) % SLOT_COUNT] && !slot_taken[target])
                    target = SLOT_W'((j + i) % SLOT_COUNT);
        end
        issue_command(op, wall_ms, KIND_W'($urandom_range(0, 3)), target, 1'b0, '0);
    endtask

    // Result checker: outputs settle after the rising edge, so sample mid-cycle.
    always @(negedge clk)
    begin
        outcome_t want;
        if (rst_n && done)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $error("result transaction with no command waiting for it");
                fail_count++;
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (slot_used !== want.slot_used)
                begin
                    $error("slot_used: expected %0d, got %0d", want.slot_used, slot_used);
                    fail_count++;
                end
                if (evicted !== want.evicted)
                begin
                    $error("evicted: expected %0d, got %0d", want.evicted, evicted);
                    fail_count++;
                end
                if (expired_mask !== want.expired_mask)
                begin
                    $error("expired_mask: expected %0h, got %0h", want.expired_mask,
                           expired_mask);
                    fail_count++;
                end
                if (active_count !== want.active_count)
                begin
                    $error("active_count: expected %0d, got %0d", want.active_count,
                           active_count);
                    fail_count++;
                end
            end
        end
    end

    // Main sequence: reset, directed table, then random phases over several timeouts.
    initial
    begin
        logic [TIMEOUT_W-1:0] phase_timeouts [7];
        fail_count = 0;
        cycle_count = 0;
        burst_left = 0;
        post_total = 0;
        evict_total = 0;
        expiry_total = 0;
        command_total = 0;
        setting_total = 1;
        timeout_setting = TIMEOUT_RESET;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            slot_taken[i] = 1'b0;
            slot_time[i] = '0;
            slot_sort[i] = '0;
        end
        rst_n <= 1'b0;
        start <= 1'b0;
        cmd <= CMD_NOP;
        now_ms <= '0;
        kind <= '0;
        slot_index <= '0;
        timeout_we <= 1'b0;
        timeout_ms <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed rows; typed results are obvious from the table contents.
        add_row(CMD_NOP,     32'd0,          2'd0, 2'd0, 1'b1, 0, 0, 0, 0);
        add_row(CMD_DISMISS, 32'd0,          2'd0, 2'd3, 1'b1, 0, 0, 0, 0);
        add_row(CMD_TICK,    32'hFFFF_FFFF,  2'd0, 2'd0, 1'b1, 0, 0, 0, 0);
        add_row(CMD_POST,    32'hFFFF_FFFF,  2'd3, 2'd0, 1'b1, 0, 0, 0, 1);
        add_row(CMD_POST,    32'hFFFF_FFFF,  2'd2, 2'd0, 1'b1, 1, 0, 0, 2);
        add_row(CMD_POST,    32'hFFFF_FFFF,  2'd1, 2'd0, 1'b1, 2, 0, 0, 3);
        add_row(CMD_POST,    32'hFFFF_FFFF,  2'd0, 2'd0, 1'b1, 3, 0, 0, 4);
        // All stamps at the maximum: the lowest index loses the tie.
        add_row(CMD_POST,    32'd0,          2'd3, 2'd0, 1'b1, 0, 1, 0, 4);
        add_row(CMD_POST,    32'd123,        2'd1, 2'd0, 1'b0, 0, 0, 0, 0);
        // Sweeps right below and right at the timeout, across the timer wrap.
        add_row(CMD_TICK,    32'd4999,       2'd0, 2'd0, 1'b0, 0, 0, 0, 0);
        add_row(CMD_TICK,    32'd5122,       2'd0, 2'd0, 1'b0, 0, 0, 0, 0);
        add_row(CMD_TICK,    32'd5123,       2'd0, 2'd0, 1'b0, 0, 0, 0, 0);
        add_row(CMD_NOP,     32'hFFFF_FFFF,  2'd3, 2'd3, 1'b1, 0, 0, 0, 0);
        add_row(CMD_POST,    32'd1000,       2'd2, 2'd0, 1'b0, 0, 0, 0, 0);
        add_row(CMD_DISMISS, 32'd0,          2'd0, 2'd0, 1'b0, 0, 0, 0, 0);
        add_row(CMD_DISMISS, 32'd0,          2'd0, 2'd0, 1'b0, 0, 0, 0, 0);
        // Equal stamps everywhere, then two evictions walking the tie order.
        add_row(CMD_POST,    32'd7,          2'd0, 2'd0, 1'b0, 0, 0, 0, 0);
        add_row(CMD_POST,    32'd7,          2'd1, 2'd0, 1'b0, 0, 0, 0, 0);
        add_row(CMD_POST,    32'd7,          2'd2, 2'd0, 1'b0, 0, 0, 0, 0);
        add_row(CMD_POST,    32'd7,          2'd3, 2'd0, 1'b0, 0, 0, 0, 0);
        add_row(CMD_POST,    32'd8,          2'd1, 2'd0, 1'b0, 0, 0, 0, 0);
        add_row(CMD_POST,    32'd9,          2'd2, 2'd0, 1'b0, 0, 0, 0, 0);
        add_row(CMD_DISMISS, 32'd0,          2'd0, 2'd2, 1'b0, 0, 0, 0, 0);
        add_row(CMD_POST,    32'd10,         2'd3, 2'd0, 1'b0, 0, 0, 0, 0);
        add_row(CMD_TICK,    32'd0,          2'd0, 2'd0, 1'b0, 0, 0, 0, 0);
        foreach (directed_rows[i])
            issue_command(directed_rows[i].op, directed_rows[i].stamp, directed_rows[i].sort,
                          directed_rows[i].target, directed_rows[i].typed,
                          directed_rows[i].want);

        // Random phases: reset timeout first, then zero, the range limits,
        // the widest register value, a random value and back to reset.
        phase_timeouts[0] = TIMEOUT_RESET;
        phase_timeouts[1] = '0;
        phase_timeouts[2] = TIMEOUT_W'(500);
        phase_timeouts[3] = TIMEOUT_W'(3600000);
        phase_timeouts[4] = '1;
        phase_timeouts[5] = TIMEOUT_W'($urandom_range(500, 3600000));
        phase_timeouts[6] = TIMEOUT_RESET;
        for (int p = 0; p < 7; p++)
        begin
            if (p != 0)
                load_timeout(phase_timeouts[p]);
            if (p % 2 == 1)
                wall_ms = 32'hFFFF_FFFF - TIME_W'($urandom_range(0, 4 * (p + 1) * 1000));
            else
                wall_ms = $urandom();
            repeat (PHASE_ITEMS) random_command();
        end

        // Drain the remaining results and allow a few cycles for stray strobes.
        start <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Ran %0d commands over %0d timeout settings: %0d posts, %0d evictions,",
                 command_total, setting_total, post_total, evict_total);
        $display("and %0d sweeps that expired at least one slot.", expiry_total);
        if (fail_count == 0)
            $display("timed_slot_table_oldest_evict verification clean");
        else
            $display("timed_slot_table_oldest_evict verification failed");
        $finish;
    end

endmodule

// File: files.f
+incdir+sv
sv/tsoe_pkg.sv
sv/timed_slot_table_oldest_evict.sv
tb/timed_slot_table_oldest_evict_tb.sv
